FILE: sv/sphpf_pkg.sv
// ----------------------------------------------------------------------------
// sphpf_pkg
// Shared types, codes and helper functions for the SPH pair force block.
// ----------------------------------------------------------------------------
package sphpf_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_RADIUS    = 3'd0;
    localparam logic [2:0] CFG_MASS      = 3'd1;
    localparam logic [2:0] CFG_VISC      = 3'd2;
    localparam logic [2:0] CFG_SPIKY     = 3'd3;
    localparam logic [2:0] CFG_VISC_LAP  = 3'd4;
    localparam logic [2:0] CFG_GRAV_X    = 3'd5;
    localparam logic [2:0] CFG_GRAV_Y    = 3'd6;

    // input action codes
    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_NEIGHBOR = 1'b1;

    // multiply-divide operation sequence, in issue order
    localparam logic [4:0] OP_PA  = 5'd0;
    localparam logic [4:0] OP_PB  = 5'd1;
    localparam logic [4:0] OP_PK  = 5'd2;
    localparam logic [4:0] OP_PP  = 5'd3;
    localparam logic [4:0] OP_PX  = 5'd4;
    localparam logic [4:0] OP_PY  = 5'd5;
    localparam logic [4:0] OP_V1  = 5'd6;
    localparam logic [4:0] OP_V2  = 5'd7;
    localparam logic [4:0] OP_V3  = 5'd8;
    localparam logic [4:0] OP_VX1 = 5'd9;
    localparam logic [4:0] OP_VX2 = 5'd10;
    localparam logic [4:0] OP_VY1 = 5'd11;
    localparam logic [4:0] OP_VY2 = 5'd12;
    localparam logic [4:0] OP_GX1 = 5'd13;
    localparam logic [4:0] OP_GX2 = 5'd14;
    localparam logic [4:0] OP_GY1 = 5'd15;
    localparam logic [4:0] OP_GY2 = 5'd16;

    // right shift codes for power-of-two denominators
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_16 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;
    localparam logic [1:0] SH_48 = 2'd3;

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int SQRT_STEPS = 24;

    typedef struct packed {
        logic       load;
        logic       latch;
        logic       sq;
        logic       cmp;
        logic       sqrt_step;
        logic       op_start;
        logic [4:0] op;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic r2_zero;
        logic last;
        logic op_done;
        logic out_free;
    } t_sts;

    // magnitude of a signed 64-bit value
    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    // saturate to signed 48 bits
    function automatic logic signed [47:0] clamp48(input logic signed [63:0] x);
        if (x > 64'sh0000_7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (x < -64'sh0000_8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end else begin
            return x[47:0];
        end
    endfunction

    // saturating accumulate of a clamped term
    function automatic logic signed [47:0] acc_add(input logic signed [47:0] acc,
                                                   input logic signed [63:0] term);
        logic signed [47:0] t;
        logic signed [48:0] s;
        t = clamp48(term);
        s = {acc[47], acc} + {t[47], t};
        if (s[48] != s[47]) begin
            return s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end
        return s[47:0];
    endfunction

endpackage

FILE: sv/sphpf_muldiv.sv
// ----------------------------------------------------------------------------
// sphpf_muldiv
// Sequential signed a*b/den unit: 64x64 product in four 32x32 steps, then a
// shift for power-of-two denominators or a bit-serial restoring divide.
// ----------------------------------------------------------------------------
module sphpf_muldiv import sphpf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  logic               i_div,
    input  logic [1:0]         i_sh,
    input  logic [63:0]        i_den,
    output logic               o_done,
    output logic signed [63:0] o_q
);
    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_MUL  = 3'd1;
    localparam logic [2:0] M_SH   = 3'd2;
    localparam logic [2:0] M_DIV  = 3'd3;
    localparam logic [2:0] M_FIN  = 3'd4;

    logic [2:0]         r_st;
    logic [6:0]         r_cnt;
    logic               r_done;
    logic [63:0]        r_ma, r_mb, r_den, r_rem;
    logic               r_neg, r_div;
    logic [1:0]         r_sh;
    logic [127:0]       r_prod;
    logic signed [63:0] r_q;

    logic [31:0]  a_sl, b_sl;
    logic [63:0]  pp;
    logic [127:0] pp_sh, sh_val;
    logic [63:0]  rem2, qmag;
    logic         ge;

    // partial product of the current 32-bit halves
    assign a_sl = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
    assign b_sl = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
    assign pp   = a_sl * b_sl;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_comb begin
        case (r_sh)
            SH_0:    sh_val = r_prod;
            SH_16:   sh_val = r_prod >> 16;
            SH_32:   sh_val = r_prod >> 32;
            SH_48:   sh_val = r_prod >> 48;
            default: sh_val = r_prod;
        endcase
    end

    // one restoring divide step
    assign rem2 = {r_rem[62:0], r_prod[127]};
    assign ge   = (rem2 >= r_den);
    assign qmag = (|r_prod[127:63]) ? MAG_MAX : r_prod[63:0];

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= M_IDLE;
            r_cnt  <= 7'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                M_IDLE: begin
                    if (i_start) begin
                        r_st  <= M_MUL;
                        r_cnt <= 7'd0;
                    end
                end
                M_MUL: begin
                    if (r_cnt == 7'd3) begin
                        r_st  <= r_div ? M_DIV : M_SH;
                        r_cnt <= 7'd0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                M_SH: r_st <= M_FIN;
                M_DIV: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_st <= M_FIN;
                    end
                end
                M_FIN: begin
                    r_done <= 1'b1;
                    r_st   <= M_IDLE;
                end
                default: r_st <= M_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_st)
            M_IDLE: begin
                if (i_start) begin
                    r_ma   <= mag64(i_a);
                    r_mb   <= mag64(i_b);
                    r_neg  <= i_a[63] ^ i_b[63];
                    r_div  <= i_div;
                    r_sh   <= i_sh;
                    r_den  <= (i_den == 64'd0) ? 64'd1 : i_den;
                    r_prod <= 128'd0;
                    r_rem  <= 64'd0;
                end
            end
            M_MUL: r_prod <= r_prod + pp_sh;
            M_SH:  r_prod <= sh_val;
            M_DIV: begin
                r_rem  <= ge ? (rem2 - r_den) : rem2;
                r_prod <= {r_prod[126:0], ge};
            end
            M_FIN: r_q <= r_neg ? -$signed(qmag) : $signed(qmag);
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

FILE: sv/sphpf_datapath.sv
// ----------------------------------------------------------------------------
// sphpf_datapath
// Configuration, centre and accumulator registers, range test, square root
// and operand routing to the shared multiply-divide unit.
// ----------------------------------------------------------------------------
module sphpf_datapath import sphpf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [55:0]        i_cfg_data,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [39:0] i_pressure_in,
    input  logic [39:0]        i_density_in,
    input  logic               i_is_self,
    input  logic               i_last,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y
);
    // configuration
    logic [23:0]        r_radius, r_mass;
    logic [31:0]        r_visc;
    logic signed [55:0] r_spiky, r_vlc;
    logic signed [31:0] r_gx, r_gy;
    // centre particle and accumulators
    logic signed [31:0] r_cpx, r_cpy, r_cvx, r_cvy;
    logic signed [39:0] r_cpr;
    logic [39:0]        r_crho;
    logic signed [47:0] r_acc_x, r_acc_y;
    // neighbour item
    logic signed [32:0] r_rx, r_ry, r_dvx, r_dvy;
    logic signed [40:0] r_prs;
    logic [39:0]        r_rho;
    logic               r_self, r_last;
    // range test and root
    logic               r_inr, r_hit, r_r2z;
    logic [47:0]        r_sqx, r_sqy, r_hh;
    logic [47:0]        r_sv, r_res, r_bit;
    // intermediate terms
    logic signed [63:0] r_t1, r_tk, r_tp, r_tv;
    logic signed [47:0] r_gtx, r_gty;
    // result
    logic               r_ovld;
    logic signed [47:0] r_fx, r_fy;

    logic [39:0]        rho_in;
    logic [32:0]        magrx, magry;
    logic [48:0]        r2sum;
    logic [47:0]        rb;
    logic [23:0]        d24;
    logic [47:0]        dd;
    logic signed [63:0] op_a, op_b, md_q;
    logic               op_div, md_done;
    logic [1:0]         op_sh;
    logic [63:0]        op_den;

    assign rho_in = (i_density_in == 40'd0) ? 40'd1 : i_density_in;
    assign magrx  = r_rx[32] ? (~r_rx + 33'd1) : r_rx;
    assign magry  = r_ry[32] ? (~r_ry + 33'd1) : r_ry;
    assign r2sum  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign rb     = r_res + r_bit;
    assign d24    = r_radius - r_res[23:0];
    assign dd     = d24 * d24;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 24'd1048576;
            r_mass   <= 24'd163840;
            r_visc   <= 32'd13107200;
            r_spiky  <= -56'sd854457600;
            r_vlc    <= 56'sd3417830400;
            r_gx     <= 32'sd0;
            r_gy     <= 32'sd655360;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS:   r_radius <= i_cfg_data[23:0];
                CFG_MASS:     r_mass   <= i_cfg_data[23:0];
                CFG_VISC:     r_visc   <= i_cfg_data[31:0];
                CFG_SPIKY:    r_spiky  <= i_cfg_data;
                CFG_VISC_LAP: r_vlc    <= i_cfg_data;
                CFG_GRAV_X:   r_gx     <= i_cfg_data[31:0];
                CFG_GRAV_Y:   r_gy     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // operand routing per operation
    always_comb begin
        op_a   = 64'sd0;
        op_b   = 64'sd0;
        op_div = 1'b0;
        op_sh  = SH_0;
        op_den = 64'd1;
        case (i_cmd.op)
            OP_PA: begin
                op_a = {40'd0, r_mass};
                op_b = {{23{r_prs[40]}}, r_prs};
                op_sh = SH_16;
            end
            OP_PB: begin
                op_a = r_t1;
                op_b = 64'sh10_0000_0000;
                op_div = 1'b1;
                op_den = {23'd0, r_rho, 1'b0};
            end
            OP_PK: begin
                op_a = {{8{r_spiky[55]}}, r_spiky};
                op_b = {16'd0, dd};
                op_sh = SH_48;
            end
            OP_PP: begin
                op_a = r_t1;
                op_b = r_tk;
                op_sh = SH_32;
            end
            OP_PX, OP_PY: begin
                op_a = r_tp;
                op_b = (i_cmd.op == OP_PX) ? {{31{r_rx[32]}}, r_rx}
                                           : {{31{r_ry[32]}}, r_ry};
                op_div = 1'b1;
                op_den = {39'd0, r_res[24:0]};
            end
            OP_V1: begin
                op_a = {32'd0, r_visc};
                op_b = {40'd0, r_mass};
            end
            OP_V2: begin
                op_a = r_tv;
                op_b = {{8{r_vlc[55]}}, r_vlc};
                op_sh = SH_48;
            end
            OP_V3: begin
                op_a = r_tv;
                op_b = {40'd0, d24};
                op_sh = SH_16;
            end
            OP_VX1, OP_VY1: begin
                op_a = r_tv;
                op_b = (i_cmd.op == OP_VX1) ? {{31{r_dvx[32]}}, r_dvx}
                                            : {{31{r_dvy[32]}}, r_dvy};
                op_sh = SH_16;
            end
            OP_VX2, OP_VY2: begin
                op_a = r_t1;
                op_b = 64'sh10_0000;
                op_div = 1'b1;
                op_den = {24'd0, r_rho};
            end
            OP_GX1, OP_GY1: begin
                op_a = (i_cmd.op == OP_GX1) ? {{32{r_gx[31]}}, r_gx}
                                            : {{32{r_gy[31]}}, r_gy};
                op_b = {40'd0, r_mass};
                op_sh = SH_16;
            end
            OP_GX2, OP_GY2: begin
                op_a = r_t1;
                op_b = 64'sh10_0000_0000;
                op_div = 1'b1;
                op_den = {24'd0, r_crho};
            end
            default: ;
        endcase
    end

    sphpf_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_div   (op_div),
        .i_sh    (op_sh),
        .i_den   (op_den),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    // centre particle and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpx   <= 32'sd0;
            r_cpy   <= 32'sd0;
            r_cvx   <= 32'sd0;
            r_cvy   <= 32'sd0;
            r_cpr   <= 40'sd0;
            r_crho  <= 40'd1;
            r_acc_x <= 48'sd0;
            r_acc_y <= 48'sd0;
        end else if (i_cmd.load) begin
            r_cpx   <= i_pos_x;
            r_cpy   <= i_pos_y;
            r_cvx   <= i_vel_x;
            r_cvy   <= i_vel_y;
            r_cpr   <= i_pressure_in;
            r_crho  <= rho_in;
            r_acc_x <= 48'sd0;
            r_acc_y <= 48'sd0;
        end else if (md_done) begin
            case (i_cmd.op)
                OP_PX:   r_acc_x <= acc_add(r_acc_x, -md_q);
                OP_PY:   r_acc_y <= acc_add(r_acc_y, -md_q);
                OP_VX2:  r_acc_x <= acc_add(r_acc_x, md_q);
                OP_VY2:  r_acc_y <= acc_add(r_acc_y, md_q);
                default: ;
            endcase
        end
    end

    // neighbour latch, range test, square root, term registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_rx   <= {i_pos_x[31], i_pos_x} - {r_cpx[31], r_cpx};
            r_ry   <= {i_pos_y[31], i_pos_y} - {r_cpy[31], r_cpy};
            r_dvx  <= {i_vel_x[31], i_vel_x} - {r_cvx[31], r_cvx};
            r_dvy  <= {i_vel_y[31], i_vel_y} - {r_cvy[31], r_cvy};
            r_prs  <= {i_pressure_in[39], i_pressure_in} + {r_cpr[39], r_cpr};
            r_rho  <= rho_in;
            r_self <= i_is_self;
            r_last <= i_last;
        end
        if (i_cmd.sq) begin
            r_inr <= !r_self && (magrx < {9'd0, r_radius}) && (magry < {9'd0, r_radius});
            r_sqx <= magrx[23:0] * magrx[23:0];
            r_sqy <= magry[23:0] * magry[23:0];
            r_hh  <= r_radius * r_radius;
        end
        if (i_cmd.cmp) begin
            r_hit <= r_inr && (r2sum < {1'b0, r_hh});
            r_r2z <= (r2sum == 49'd0);
            r_sv  <= r2sum[47:0];
            r_res <= 48'd0;
            r_bit <= 48'h4000_0000_0000;
        end
        if (i_cmd.sqrt_step) begin
            if (r_sv >= rb) begin
                r_sv  <= r_sv - rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (md_done) begin
            case (i_cmd.op)
                OP_PA, OP_PB, OP_VX1, OP_VY1, OP_GX1, OP_GY1: r_t1 <= md_q;
                OP_PK:   r_tk <= md_q;
                OP_PP:   r_tp <= md_q;
                OP_V1, OP_V2, OP_V3: r_tv <= md_q;
                OP_GX2:  r_gtx <= clamp48(md_q);
                OP_GY2:  r_gty <= clamp48(md_q);
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_fx <= acc_add(r_acc_x, {{16{r_gtx[47]}}, r_gtx});
            r_fy <= acc_add(r_acc_y, {{16{r_gty[47]}}, r_gty});
        end
    end

    assign o_sts.hit      = r_hit;
    assign o_sts.r2_zero  = r_r2z;
    assign o_sts.last     = r_last;
    assign o_sts.op_done  = md_done;
    assign o_sts.out_free = !r_ovld || i_out_ready;

    assign o_out_valid = r_ovld;
    assign o_force_x   = r_fx;
    assign o_force_y   = r_fy;

endmodule

FILE: sv/sphpf_ctrl.sv
// ----------------------------------------------------------------------------
// sphpf_ctrl
// Controller: accepts items, steps the range test and root, and issues the
// multiply-divide operations of each neighbour and of the gravity term.
// ----------------------------------------------------------------------------
module sphpf_ctrl import sphpf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_action,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQ    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_ISSUE = 3'd5;
    localparam logic [2:0] S_WAIT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_st;
    logic [4:0] r_op;
    logic [4:0] r_cnt;
    logic       accept;

    assign o_in_ready = (r_st == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_cmd.load      = accept && (i_action == ACT_LOAD);
        o_cmd.latch     = accept && (i_action == ACT_NEIGHBOR);
        o_cmd.sq        = (r_st == S_SQ);
        o_cmd.cmp       = (r_st == S_CMP);
        o_cmd.sqrt_step = (r_st == S_SQRT);
        o_cmd.op_start  = (r_st == S_ISSUE);
        o_cmd.out_load  = (r_st == S_OUT) && i_sts.out_free;
    end

    // state sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_op  <= OP_PA;
            r_cnt <= 5'd0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (o_cmd.latch) begin
                        r_st <= S_SQ;
                    end
                end
                S_SQ:  r_st <= S_CMP;
                S_CMP: r_st <= S_CHK;
                S_CHK: begin
                    r_cnt <= 5'd0;
                    if (i_sts.hit) begin
                        r_st <= S_SQRT;
                    end else if (i_sts.last) begin
                        r_st <= S_ISSUE;
                        r_op <= OP_GX1;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                        r_st <= S_ISSUE;
                        r_op <= i_sts.r2_zero ? OP_V1 : OP_PA;
                    end
                end
                S_ISSUE: r_st <= S_WAIT;
                S_WAIT: begin
                    if (i_sts.op_done) begin
                        if (r_op == OP_VY2) begin
                            if (i_sts.last) begin
                                r_st <= S_ISSUE;
                                r_op <= OP_GX1;
                            end else begin
                                r_st <= S_IDLE;
                            end
                        end else if (r_op == OP_GY2) begin
                            r_st <= S_OUT;
                        end else begin
                            r_op <= r_op + 5'd1;
                            r_st <= S_ISSUE;
                        end
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/sph_pair_force_accumulator_unit.sv
// A load item leaves the block idle. A neighbour item in range holds the block
// through the range test and 24-step root, then eight shift and five divide
// operations (from the viscosity ones on if the distance is zero). Out of
// range or self: no operations. A last neighbour adds the gravity term, then
// waits for a free output register. One item at a time, as the block shares
// one multiply-divide unit. Reset (synchronous, active low) restores config.
// ----------------------------------------------------------------------------
// sph_pair_force_accumulator_unit
// Top level: 2-D SPH pressure and viscosity force accumulator, fixed point.
// ----------------------------------------------------------------------------
module sph_pair_force_accumulator_unit import sphpf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [55:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [39:0] i_pressure_in,
    input  logic [39:0]        i_density_in,
    input  logic               i_is_self,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y
);
    t_cmd cmd;
    t_sts sts;

    sphpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sphpf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_pressure_in (i_pressure_in),
        .i_density_in  (i_density_in),
        .i_is_self     (i_is_self),
        .i_last        (i_last),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_force_x     (o_force_x),
        .o_force_y     (o_force_y)
    );

    // no operation completes while the block is taking items
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.op_done |-> !o_in_ready)
        else $error("operation completed while idle");

    // a neighbour item starts work
    a_nb_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == ACT_NEIGHBOR) |=> !o_in_ready)
        else $error("neighbour item did not start work");

    // a load item leaves the block ready for the next item
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == ACT_LOAD) |=> o_in_ready)
        else $error("load item left the block busy");

    // a result is only loaded when the output register is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result overwrote a pending result");

endmodule
